// ----- sv/slor_pkg.sv -----
// Package: shape table types, codes and sizing constants for the outline rasterizer.
`default_nettype none
package slor_pkg;
	localparam int CANVAS_ROWS_DEF = 20;
	localparam int CANVAS_COLS_DEF = 40;
	localparam int TABLE_DEPTH_DEF = 10;
	localparam int PIX_W = 40;
	localparam int ROW_W = 5;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_MOVE   = 2'd2,
		ACT_RENDER = 2'd3
	} action_t;

	localparam logic [1:0] KIND_RECT   = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_LINE   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BADIX = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [1:0]        shape_kind;
		logic signed [7:0] x_a;
		logic signed [7:0] y_a;
		logic signed [7:0] x_b;
		logic signed [7:0] y_b;
		logic signed [7:0] radius;
		logic [3:0]        entry_index;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PIX_W-1:0] row_pixels;
		logic [ROW_W-1:0] row_number;
		logic             last_row;
		logic [3:0]       shape_count;
	} res_word_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic signed [7:0] xa;
		logic signed [7:0] ya;
		logic signed [7:0] xb;
		logic signed [7:0] yb;
		logic signed [7:0] rad;
	} shape_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL_RD,
		S_DEL_WR,
		S_RND_RD,
		S_RND_ACC,
		S_RND_OUT,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- sv/shape_list_outline_rasterizer.sv -----
// Top level: shape table in a synchronous memory, add/delete/move and row-by-row render.
//
// Usage: drive cmd and pulse start while busy is low; the word is taken at that edge.
// Results appear on res for one cycle each, marked by res_valid; the receiver cannot
// stall, so every result must be taken when shown.
// Add, move and bad-index commands go through the done state, which registers one result.
// Delete shifts later entries down through the memory, a read state and then a write
// state per moved entry, then gives one result.
// Render reads each stored shape once per row from the table memory, a read state and
// then an accumulate state per shape, all columns evaluated in parallel. Rows come out in
// order, last_row marks the final one.
// busy stays high from acceptance until the last result is registered; it drops in
// the cycle that shows the last result, so the next word can be taken at that edge.
// Reset clears the shape count and control; the table memory itself is not cleared,
// since only entries below the count are ever used.
`default_nettype none
module shape_list_outline_rasterizer import slor_pkg::*; #(
	parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
	parameter int CANVAS_COLS = CANVAS_COLS_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire cmd_word_t cmd,
	output logic           busy,
	output logic           res_valid,
	output res_word_t      res
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int RW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

	shape_t mem [TABLE_DEPTH];
	shape_t rd_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	shape_t        wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	state_t state_q, state_d;
	logic [3:0]       count_q;
	logic [3:0]       ptr_q;
	logic [RW-1:0]    row_q;
	logic [63:0]      mask_q;
	logic [1:0]       status_q;
	cmd_word_t        cmd_q;

	logic [63:0] row_mask;
	always_comb begin
		logic signed [9:0]  ii, jj, dx, dy;
		logic [19:0]        d, r2, r12;
		logic               on;
		row_mask = '0;
		ii = 10'(row_q);
		dy = ii - 10'(rd_q.ya);
		r2 = 20'(rd_q.rad * rd_q.rad);
		r12 = 20'(($signed(10'(rd_q.rad)) + 10'sd1) * ($signed(10'(rd_q.rad)) + 10'sd1));
		for (int j = 0; j < CANVAS_COLS; j++) begin
			jj = 10'(j);
			dx = jj - 10'(rd_q.xa);
			d = 20'(dx * dx) + 20'(dy * dy);
			on = 1'b0;
			case (rd_q.kind)
				KIND_RECT: on = ii >= rd_q.ya && ii <= rd_q.yb && jj >= rd_q.xa &&
					jj <= rd_q.xb && (ii == rd_q.ya || ii == rd_q.yb ||
					jj == rd_q.xa || jj == rd_q.xb);
				KIND_CIRCLE: on = !rd_q.rad[7] && r2 <= d && d < r12;
				KIND_LINE: begin
					if (rd_q.ya == rd_q.yb)
						on = ii == rd_q.ya && jj >= rd_q.xa && jj <= rd_q.xb;
					else if (rd_q.xa == rd_q.xb)
						on = jj == rd_q.xa && ii >= rd_q.ya && ii <= rd_q.yb;
				end
				default: on = 1'b0;
			endcase
			row_mask[j] = on;
		end
	end

	logic idx_ok;
	assign idx_ok = {1'b0, cmd.entry_index} < {1'b0, count_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) begin
				case (cmd.action)
					ACT_DELETE: state_d = idx_ok ? S_DEL_RD : S_DONE;
					ACT_RENDER: state_d = S_RND_RD;
					default:    state_d = S_DONE;
				endcase
			end
			S_DEL_RD:  state_d = (ptr_q + 4'd1 < count_q) ? S_DEL_WR : S_DONE;
			S_DEL_WR:  state_d = S_DEL_RD;
			S_RND_RD:  state_d = (ptr_q < count_q) ? S_RND_ACC : S_RND_OUT;
			S_RND_ACC: state_d = S_RND_RD;
			S_RND_OUT: state_d = (row_q == RW'(CANVAS_ROWS - 1)) ? S_IDLE : S_RND_RD;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = AW'(count_q);
		wdata = rd_q;
		raddr = AW'(ptr_q);
		case (state_q)
			S_IDLE: if (start) begin
				if (cmd.action == ACT_ADD && count_q < 4'(TABLE_DEPTH) &&
					cmd.shape_kind != 2'd3) begin
					we = 1'b1;
					waddr = AW'(count_q);
					wdata = '{cmd.shape_kind, cmd.x_a, cmd.y_a, cmd.x_b, cmd.y_b,
						cmd.radius};
				end
				raddr = AW'(cmd.entry_index);
			end
			S_DEL_RD: raddr = AW'(ptr_q + 4'd1);
			S_DEL_WR: begin
				we = 1'b1;
				waddr = AW'(ptr_q);
			end
			S_DONE: if (cmd_q.action == ACT_MOVE && status_q == ST_OK) begin
				we = 1'b1;
				waddr = AW'(cmd_q.entry_index);
				wdata = rd_q;
				wdata.xa = cmd_q.x_a;
				wdata.ya = cmd_q.y_a;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			row_q <= '0;
			status_q <= ST_OK;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					ptr_q <= (cmd.action == ACT_RENDER) ? 4'd0 : cmd.entry_index;
					row_q <= '0;
					mask_q <= '0;
					status_q <= ST_OK;
					case (cmd.action)
						ACT_ADD: begin
							if (count_q >= 4'(TABLE_DEPTH)) status_q <= ST_FULL;
							else if (cmd.shape_kind != 2'd3) count_q <= count_q + 4'd1;
						end
						ACT_DELETE, ACT_MOVE: if (!idx_ok) status_q <= ST_BADIX;
						default: ;
					endcase
				end
				S_DEL_RD: if (!(ptr_q + 4'd1 < count_q)) count_q <= count_q - 4'd1;
				S_DEL_WR: ptr_q <= ptr_q + 4'd1;
				S_RND_ACC: begin
					mask_q <= mask_q | row_mask;
					ptr_q <= ptr_q + 4'd1;
				end
				S_RND_OUT: begin
					res_valid <= 1'b1;
					res.status <= ST_OK;
					res.row_pixels <= PIX_W'(mask_q);
					res.row_number <= ROW_W'(row_q);
					res.last_row <= (row_q == RW'(CANVAS_ROWS - 1));
					res.shape_count <= count_q;
					mask_q <= '0;
					ptr_q <= '0;
					row_q <= row_q + RW'(1);
				end
				S_DONE: begin
					res_valid <= 1'b1;
					res.status <= status_q;
					res.row_pixels <= '0;
					res.row_number <= '0;
					res.last_row <= 1'b1;
					res.shape_count <= count_q;
				end
				default: ;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the shape list outline rasterizer: directed and random commands against a local model.
`default_nettype none
module testbench;
	import slor_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      start;
	cmd_word_t cmd;
	logic      busy;
	logic      res_valid;
	res_word_t res;

	shape_list_outline_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .res_valid(res_valid), .res(res)
	);

	shape_t    shapes[TABLE_DEPTH_DEF];
	int        n_shapes;
	res_word_t want_q[$];
	int        errors;
	int        idle_pct;
	int        n_sent;
	int        n_renders;
	int        n_words;
	longint    cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic bit pixel_hit(shape_t s, int i, int j);
		int dx, dy, d, r;
		case (s.kind)
			KIND_RECT: begin
				if (i < s.ya || i > s.yb || j < s.xa || j > s.xb)
					return 0;
				return i == s.ya || i == s.yb || j == s.xa || j == s.xb;
			end
			KIND_CIRCLE: begin
				if (s.rad < 0)
					return 0;
				dx = j - s.xa;
				dy = i - s.ya;
				d = dx * dx + dy * dy;
				r = s.rad;
				return r * r <= d && d < (r + 1) * (r + 1);
			end
			KIND_LINE: begin
				if (s.ya == s.yb)
					return i == s.ya && j >= s.xa && j <= s.xb;
				if (s.xa == s.xb)
					return j == s.xa && i >= s.ya && i <= s.yb;
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	// Updates the shape table and queues the words this command yields.
	task automatic predict_canvas(cmd_word_t c);
		res_word_t w;
		logic [PIX_W-1:0] mask;
		w = '0;
		w.last_row = 1'b1;
		case (action_t'(c.action))
			ACT_ADD: begin
				if (n_shapes >= TABLE_DEPTH_DEF)
					w.status = ST_FULL;
				else if (c.shape_kind <= KIND_LINE) begin
					shapes[n_shapes] = '{c.shape_kind, c.x_a, c.y_a, c.x_b, c.y_b, c.radius};
					n_shapes++;
				end
			end
			ACT_DELETE: begin
				if (c.entry_index >= n_shapes)
					w.status = ST_BADIX;
				else begin
					for (int k = c.entry_index; k + 1 < n_shapes; k++)
						shapes[k] = shapes[k + 1];
					n_shapes--;
				end
			end
			ACT_MOVE: begin
				if (c.entry_index >= n_shapes)
					w.status = ST_BADIX;
				else begin
					shapes[c.entry_index].xa = c.x_a;
					shapes[c.entry_index].ya = c.y_a;
				end
			end
			default: begin
				for (int i = 0; i < CANVAS_ROWS_DEF; i++) begin
					mask = '0;
					for (int j = 0; j < CANVAS_COLS_DEF; j++)
						for (int k = 0; k < n_shapes; k++)
							if (pixel_hit(shapes[k], i, j))
								mask[j] = 1'b1;
					w.status = ST_OK;
					w.row_pixels = mask;
					w.row_number = i[ROW_W-1:0];
					w.last_row = (i == CANVAS_ROWS_DEF - 1);
					w.shape_count = n_shapes[3:0];
					want_q.push_back(w);
				end
				n_renders++;
				return;
			end
		endcase
		w.shape_count = n_shapes[3:0];
		want_q.push_back(w);
	endtask

	always @(posedge clk) begin
		res_word_t w;
		if (arst_n && res_valid) begin
			n_words++;
			if (want_q.size() == 0) begin
				$error("unexpected result word %h", res);
				errors++;
			end else begin
				w = want_q.pop_front();
				if (res.status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, res.status);
					errors++;
				end
				if (res.row_pixels !== w.row_pixels) begin
					$error("row_pixels: expected %h, got %h", w.row_pixels, res.row_pixels);
					errors++;
				end
				if (res.row_number !== w.row_number) begin
					$error("row_number: expected %0d, got %0d", w.row_number,
						res.row_number);
					errors++;
				end
				if (res.last_row !== w.last_row) begin
					$error("last_row: expected %0d, got %0d", w.last_row, res.last_row);
					errors++;
				end
				if (res.shape_count !== w.shape_count) begin
					$error("shape_count: expected %0d, got %0d", w.shape_count,
						res.shape_count);
					errors++;
				end
			end
		end
	end

	// start stays high into the next word unless the sender idles.
	task automatic send_cmd(cmd_word_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_canvas(c);
		n_sent++;
	endtask

	function automatic cmd_word_t mk(action_t a, logic [1:0] k, int xa, int ya, int xb,
		int yb, int r, int ix);
		cmd_word_t c;
		c.action = a;
		c.shape_kind = k;
		c.x_a = xa[7:0];
		c.y_a = ya[7:0];
		c.x_b = xb[7:0];
		c.y_b = yb[7:0];
		c.radius = r[7:0];
		c.entry_index = ix[3:0];
		return c;
	endfunction

	task automatic test_directed();
		send_cmd(mk(ACT_RENDER, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(ACT_DELETE, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(ACT_MOVE, 0, 0, 0, 0, 0, 0, 15));
		send_cmd(mk(ACT_ADD, KIND_RECT, 2, 3, 30, 15, 0, 0));
		send_cmd(mk(ACT_ADD, KIND_CIRCLE, 20, 10, 0, 0, 6, 0));
		send_cmd(mk(ACT_ADD, KIND_LINE, -128, 5, 127, 5, 0, 0));
		send_cmd(mk(ACT_ADD, KIND_LINE, 39, -128, 39, 127, 0, 0));
		send_cmd(mk(ACT_ADD, 2'd3, 1, 1, 1, 1, 1, 0));
		send_cmd(mk(ACT_ADD, KIND_RECT, 10, 10, 5, 5, 0, 0));
		send_cmd(mk(ACT_ADD, KIND_CIRCLE, 5, 5, 0, 0, -1, 0));
		send_cmd(mk(ACT_ADD, KIND_LINE, 1, 1, 9, 9, 0, 0));
		send_cmd(mk(ACT_ADD, KIND_CIRCLE, -128, 127, 0, 0, 127, 0));
		send_cmd(mk(ACT_ADD, KIND_CIRCLE, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(ACT_ADD, KIND_RECT, -128, -128, 127, 127, 0, 0));
		send_cmd(mk(ACT_ADD, KIND_LINE, 5, 5, 5, 5, 0, 0));
		send_cmd(mk(ACT_RENDER, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(ACT_MOVE, 0, -1, 127, 0, 0, 0, 9));
		send_cmd(mk(ACT_MOVE, 0, 0, 0, 0, 0, 0, 10));
		send_cmd(mk(ACT_DELETE, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(ACT_DELETE, 0, 0, 0, 0, 0, 0, 8));
		send_cmd(mk(ACT_DELETE, 0, 0, 0, 0, 0, 0, 12));
		send_cmd(mk(ACT_RENDER, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Coordinates mostly near the canvas so outlines actually land on it.
	function automatic int coord(int hi);
		if ($urandom_range(9) == 0)
			return $urandom_range(255) - 128;
		return $urandom_range(hi + 4) - 4;
	endfunction

	task automatic test_random(int n, int pct);
		cmd_word_t c;
		int sel;
		idle_pct = pct;
		for (int t = 0; t < n; t++) begin
			c = 48'({$urandom, $urandom});
			sel = $urandom_range(99);
			if (sel < 40) begin
				c.action = ACT_ADD;
				c.shape_kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
				c.x_a = 8'(coord(CANVAS_COLS_DEF));
				c.y_a = 8'(coord(CANVAS_ROWS_DEF));
				c.x_b = 8'(coord(CANVAS_COLS_DEF));
				c.y_b = 8'(coord(CANVAS_ROWS_DEF));
				if (c.shape_kind == KIND_LINE && $urandom_range(1))
					c.y_b = c.y_a;
				else if (c.shape_kind == KIND_LINE && $urandom_range(1))
					c.x_b = c.x_a;
				if ($urandom_range(9) != 0)
					c.radius = 8'($urandom_range(14) - 1);
			end else if (sel < 60) begin
				c.action = ACT_DELETE;
				c.entry_index = 4'($urandom_range(4) == 0 ? $urandom_range(15)
					: $urandom_range(n_shapes > 0 ? n_shapes - 1 : 0));
			end else if (sel < 80) begin
				c.action = ACT_MOVE;
				c.entry_index = 4'($urandom_range(4) == 0 ? $urandom_range(15)
					: $urandom_range(n_shapes > 0 ? n_shapes - 1 : 0));
				c.x_a = 8'(coord(CANVAS_COLS_DEF));
				c.y_a = 8'(coord(CANVAS_ROWS_DEF));
			end else
				c.action = ACT_RENDER;
			send_cmd(c);
		end
		idle_pct = 0;
	endtask

	initial begin
		errors = 0;
		n_shapes = 0;
		idle_pct = 0;
		n_sent = 0;
		n_renders = 0;
		n_words = 0;
		cycles = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 0);
		test_random(150, 78);
		test_random(140, 19);
		start <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d commands (%0d renders), checked %0d result words.",
			n_sent, n_renders, n_words);
		if (errors == 0 && want_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
